### sv/egd_pkg.sv
// egd_pkg: shared constants and types of the order-0 exp-golomb decoder
// no dependencies; used by every module of the decoder
package egd_pkg;

    localparam int MAX_PREFIX = 31;   // longest legal prefix of zero bits
    localparam int BYTE_BITS  = 8;
    localparam int CODE_W     = 32;
    localparam int ZC_W       = 6;
    localparam int SL_W       = 5;
    localparam int SUF_W      = 31;

    // one result slot per bit position of a byte
    // v is the codeword value plus one: the leading one followed by the suffix
    typedef struct packed {
        logic              err;
        logic [CODE_W-1:0] v;
    } slot_t;

    // all results caused by one byte, mask bit j set when bit j (msb first) ends one
    typedef struct packed {
        logic [BYTE_BITS-1:0]        mask;
        slot_t [BYTE_BITS-1:0]       slots;
    } batch_t;

    // the result picked for the output register
    typedef struct packed {
        logic              err;
        logic              last;
        logic [CODE_W-1:0] v;
    } pick_t;

endpackage

### sv/egd_bit_walk.sv
// egd_bit_walk: input register, codeword state and the eight-bit walk over one byte
// depends on egd_pkg
module egd_bit_walk (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [egd_pkg::BYTE_BITS-1:0]       in_byte,
    input  logic                                in_restart,
    input  logic                                batch_free,
    output logic                                batch_take,
    output egd_pkg::batch_t                     batch
);
    import egd_pkg::*;

    logic                   hold_valid_reg;
    logic [BYTE_BITS-1:0]   hold_byte_reg;
    logic                   hold_restart_reg;

    logic                   in_suffix_reg, in_suffix_next;
    logic [ZC_W-1:0]        zero_count_reg, zero_count_next;
    logic [SL_W-1:0]        suffix_left_reg, suffix_left_next;
    logic [SUF_W-1:0]       suffix_bits_reg, suffix_bits_next;

    logic                   ins;
    logic [ZC_W-1:0]        zc;
    logic [SL_W-1:0]        sl;
    logic [SUF_W-1:0]       sb;
    logic                   cur_bit;

    assign batch_take = hold_valid_reg && batch_free;
    assign in_ready   = !hold_valid_reg || batch_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_byte_reg    <= in_byte;
            hold_restart_reg <= in_restart;
        end
    end

    // walk the bits msb first, one dependent step per bit
    always_comb
    begin
        ins = in_suffix_reg;
        zc  = zero_count_reg;
        sl  = suffix_left_reg;
        sb  = suffix_bits_reg;
        if (hold_restart_reg)
        begin
            ins = 1'b0;
            zc  = '0;
            sl  = '0;
            sb  = '0;
        end
        batch = '0;
        for (int j = 0; j < BYTE_BITS; j++)
        begin
            cur_bit = hold_byte_reg[BYTE_BITS-1-j];
            if (!ins)
            begin
                if (!cur_bit)
                begin
                    zc = zc + ZC_W'(1);
                    if (zc > ZC_W'(MAX_PREFIX))
                    begin
                        batch.mask[j]      = 1'b1;
                        batch.slots[j].err = 1'b1;
                        zc = '0;
                        sl = '0;
                        sb = '0;
                    end
                end
                else if (zc == '0)
                begin
                    batch.mask[j]    = 1'b1;
                    batch.slots[j].v = CODE_W'(1);
                end
                else
                begin
                    ins = 1'b1;
                    sl  = zc[SL_W-1:0];
                    sb  = '0;
                end
            end
            else
            begin
                sb = {sb[SUF_W-2:0], cur_bit};
                sl = sl - SL_W'(1);
                if (sl == '0)
                begin
                    batch.mask[j]    = 1'b1;
                    batch.slots[j].v = (CODE_W'(1) << zc[SL_W-1:0]) | {1'b0, sb};
                    ins = 1'b0;
                    zc  = '0;
                    sl  = '0;
                    sb  = '0;
                end
            end
        end
        in_suffix_next   = ins;
        zero_count_next  = zc;
        suffix_left_next = sl;
        suffix_bits_next = sb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_suffix_reg   <= 1'b0;
            zero_count_reg  <= '0;
            suffix_left_reg <= '0;
            suffix_bits_reg <= '0;
        end
        else if (batch_take)
        begin
            in_suffix_reg   <= in_suffix_next;
            zero_count_reg  <= zero_count_next;
            suffix_left_reg <= suffix_left_next;
            suffix_bits_reg <= suffix_bits_next;
        end
    end

endmodule

### sv/egd_result_queue.sv
// egd_result_queue: holds the results of one byte and hands them out in bit order
// depends on egd_pkg
module egd_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                batch_take,
    input  egd_pkg::batch_t     batch,
    output logic                batch_free,
    input  logic                pick_ready,
    output logic                pick_valid,
    output egd_pkg::pick_t      pick
);
    import egd_pkg::*;

    logic [BYTE_BITS-1:0]   pend_reg, pend_next;
    slot_t [BYTE_BITS-1:0]  slots_reg;
    logic [BYTE_BITS-1:0]   lowest;
    logic [BYTE_BITS-1:0]   rest;
    slot_t                  sel;

    assign lowest     = pend_reg & (~pend_reg + BYTE_BITS'(1));
    assign rest       = pend_reg & ~lowest;
    assign pick_valid = (pend_reg != '0);
    assign batch_free = !pick_valid || (rest == '0 && pick_ready);

    // one-hot select of the earliest pending slot
    always_comb
    begin
        sel = '0;
        for (int j = 0; j < BYTE_BITS; j++)
        begin
            if (lowest[j])
            begin
                sel = sel | slots_reg[j];
            end
        end
        pick.err  = sel.err;
        pick.v    = sel.v;
        pick.last = (rest == '0);
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (pick_valid && pick_ready)
        begin
            pend_next = rest;
        end
        if (batch_take)
        begin
            pend_next = batch.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (batch_take)
        begin
            slots_reg <= batch.slots;
        end
    end

endmodule

### sv/egd_out_stage.sv
// egd_out_stage: output register, forms ue and se from the picked codeword
// depends on egd_pkg
module egd_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pick_valid,
    output logic                        pick_ready,
    input  egd_pkg::pick_t              pick,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [egd_pkg::CODE_W-1:0]  code_num,
    output logic signed [egd_pkg::CODE_W-1:0] signed_value,
    output logic                        prefix_error,
    output logic                        last_of_byte
);
    import egd_pkg::*;

    logic                   out_valid_reg;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic [CODE_W-1:0]      se_reg, se_next;
    logic                   err_reg;
    logic                   last_reg;
    logic [CODE_W-1:0]      mag;

    assign pick_ready = !out_valid_reg || out_ready;

    // v = code + 1; se magnitude is v/2, negative when code is even (v odd)
    assign mag = {1'b0, pick.v[CODE_W-1:1]};

    always_comb
    begin
        if (pick.err)
        begin
            code_next = '0;
            se_next   = '0;
        end
        else
        begin
            code_next = pick.v - CODE_W'(1);
            se_next   = pick.v[0] ? (~mag + CODE_W'(1)) : mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pick_ready)
        begin
            out_valid_reg <= pick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pick_ready && pick_valid)
        begin
            code_reg <= code_next;
            se_reg   <= se_next;
            err_reg  <= pick.err;
            last_reg <= pick.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign code_num     = code_reg;
    assign signed_value = se_reg;
    assign prefix_error = err_reg;
    assign last_of_byte = last_reg;

endmodule

### sv/exp_golomb_decoder_unit.sv
// exp_golomb_decoder_unit: order-0 exp-golomb (ue/se) decoder over a byte stream
// path: a byte passes the input register and the result queue to the output register
// throughput: one byte per cycle while bytes end at most one codeword and the output
// is not stalled; a byte ending n codewords holds the input while its results drain
// reset: rst_n clears all valid flags and the codeword state (counting prefix zeros)
// depends on egd_pkg, egd_bit_walk, egd_result_queue, egd_out_stage
module exp_golomb_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    input  logic        s_axis_tuser,   // [0] restart
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] code_num, [63:32] signed_value
    output logic        m_axis_tuser,   // [0] prefix_error
    output logic        m_axis_tlast    // last_of_byte
);
    import egd_pkg::*;

    // byte stage to result queue
    logic                   batch_free;
    logic                   batch_take;
    batch_t                 batch;

    // result queue to output register
    logic                   pick_valid;
    logic                   pick_ready;
    pick_t                  pick;

    logic [CODE_W-1:0]      code_num;
    logic signed [CODE_W-1:0] signed_value;

    // input register plus the bit walk that finds every codeword ending in the byte
    egd_bit_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_restart (s_axis_tuser),
        .batch_free (batch_free),
        .batch_take (batch_take),
        .batch      (batch)
    );

    // per-byte result list, drained one entry a cycle in bit order while the output takes it
    egd_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch_take (batch_take),
        .batch      (batch),
        .batch_free (batch_free),
        .pick_ready (pick_ready),
        .pick_valid (pick_valid),
        .pick       (pick)
    );

    // output register with the ue/se arithmetic in front of it
    egd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .pick_valid   (pick_valid),
        .pick_ready   (pick_ready),
        .pick         (pick),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .code_num     (code_num),
        .signed_value (signed_value),
        .prefix_error (m_axis_tuser),
        .last_of_byte (m_axis_tlast)
    );

    assign m_axis_tdata = {signed_value, code_num};

    // a new byte batch is only taken once the previous list is drained or finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        batch_take |-> (!pick_valid || (pick.last && pick_ready)))
        else $error("byte batch taken while earlier results still pending");

    // a stalled pick keeps the same entry at the head of the list
    assert property (@(posedge clk) disable iff (!rst_n)
        (pick_valid && !pick_ready) |=> (pick_valid && $stable(pick)))
        else $error("pending result lost while output stalled");

    // an error result carries zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("prefix error result with nonzero value");

    // se agrees with ue: odd codes positive (k+1)/2, even codes -(k/2)
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        (code_num[0] ? (signed_value == signed'((code_num >> 1) + 32'd1))
                     : (signed_value == signed'(32'd0 - (code_num >> 1)))))
        else $error("signed mapping does not match code number");

endmodule

### test/tb_exp_golomb_decoder_unit.sv
// tb_exp_golomb_decoder_unit: self-checking testbench of the exp-golomb ue/se byte-stream decoder
// drives bytes with random gaps and restarts, predicts every codeword result and checks in order
// depends on egd_pkg and exp_golomb_decoder_unit
module tb_exp_golomb_decoder_unit;

    import egd_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_PCT      = 38;       // chance of an idle cycle on either side
    localparam int SETTLE_CYCLES = 12;       // idle wait once every expected result is out
    localparam int CYCLE_LIMIT   = 200000;

    // one expected or observed result transaction
    typedef struct packed {
        logic [31:0] code_num;
        logic [31:0] signed_value;
        logic        prefix_error;
        logic        last_of_byte;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] stream_byte
    logic        s_axis_tuser = 1'b0;    // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [31:0] code_num, [63:32] signed_value
    logic        m_axis_tuser;           // [0] prefix_error
    logic        m_axis_tlast;           // last_of_byte

    // expected results in arrival order
    result_t pending_results[$];
    result_t seen_result;
    result_t want_result;

    // predicted codeword state, carried from byte to byte
    logic        dec_in_suffix   = 1'b0;
    logic [5:0]  dec_zero_count  = '0;
    logic [4:0]  dec_suffix_left = '0;
    logic [30:0] dec_suffix_bits = '0;

    // bits of a well-formed stream waiting to be packed into bytes
    logic stream_bits[$];

    int   error_count = 0;
    int   bytes_sent = 0;
    int   cycle_count = 0;
    logic steady_stretch = 1'b0;   // both sides stop idling while set

    exp_golomb_decoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // watchdog: a hung handshake ends the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= steady_stretch || ($urandom_range(99) >= IDLE_PCT);
    end

    // ue value with its se mapping; error results carry zeros
    function automatic result_t make_result(input logic [31:0] code, input logic err);
        result_t r;
        r.code_num     = err ? 32'd0 : code;
        if (err)
            r.signed_value = 32'd0;
        else if (code[0])
            r.signed_value = {1'b0, code[31:1]} + 32'd1;   // odd k -> (k+1)/2
        else
            r.signed_value = 32'd0 - {1'b0, code[31:1]};   // even k -> -(k/2)
        r.prefix_error = err;
        r.last_of_byte = 1'b0;
        return r;
    endfunction

    // walk one accepted byte msb first and queue every codeword it completes
    task automatic predict_byte(input logic [7:0] b, input logic rs);
        logic        bit_in;
        logic        produced;
        logic        have_held;
        logic [31:0] code;
        result_t     fresh;
        result_t     held;
        have_held = 1'b0;
        held      = '0;
        fresh     = '0;
        if (rs)
        begin
            dec_in_suffix   = 1'b0;
            dec_zero_count  = '0;
            dec_suffix_left = '0;
            dec_suffix_bits = '0;
        end
        for (int i = 7; i >= 0; i--)
        begin
            bit_in   = b[i];
            produced = 1'b0;
            if (!dec_in_suffix)
            begin
                if (!bit_in)
                begin
                    dec_zero_count = dec_zero_count + 6'd1;
                    // prefix too long: error result, then count afresh
                    if (dec_zero_count > MAX_PREFIX)
                    begin
                        fresh          = make_result(32'd0, 1'b1);
                        produced       = 1'b1;
                        dec_zero_count = '0;
                    end
                end
                else if (dec_zero_count == 0)
                begin
                    // lone one bit is code 0
                    fresh    = make_result(32'd0, 1'b0);
                    produced = 1'b1;
                end
                else
                begin
                    dec_in_suffix   = 1'b1;
                    dec_suffix_left = dec_zero_count[4:0];
                    dec_suffix_bits = '0;
                end
            end
            else
            begin
                dec_suffix_bits = {dec_suffix_bits[29:0], bit_in};
                dec_suffix_left = dec_suffix_left - 5'd1;
                if (dec_suffix_left == 0)
                begin
                    code = ((32'd1 << dec_zero_count[4:0]) - 32'd1) + {1'b0, dec_suffix_bits};
                    fresh           = make_result(code, 1'b0);
                    produced        = 1'b1;
                    dec_in_suffix   = 1'b0;
                    dec_zero_count  = '0;
                    dec_suffix_left = '0;
                    dec_suffix_bits = '0;
                end
            end
            // hold back the newest result so the byte's final one can be tagged last
            if (produced)
            begin
                if (have_held)
                    pending_results = {pending_results, held};
                held      = fresh;
                have_held = 1'b1;
            end
        end
        if (have_held)
        begin
            held.last_of_byte = 1'b1;
            pending_results = {pending_results, held};
        end
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic rs);
        while (!steady_stretch && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(255));
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= rs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_byte(b, rs);
        bytes_sent++;
    endtask

    // hold off the input until every expected result is out
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result checker: each transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_result.code_num     = m_axis_tdata[31:0];
            seen_result.signed_value = m_axis_tdata[63:32];
            seen_result.prefix_error = m_axis_tuser;
            seen_result.last_of_byte = m_axis_tlast;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got code_num %h se %h err %b last %b",
                         $time, seen_result.code_num, seen_result.signed_value,
                         seen_result.prefix_error, seen_result.last_of_byte);
                error_count++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (seen_result.code_num !== want_result.code_num)
                begin
                    $display("%0t: code_num expected %h got %h", $time,
                             want_result.code_num, seen_result.code_num);
                    error_count++;
                end
                if (seen_result.signed_value !== want_result.signed_value)
                begin
                    $display("%0t: signed_value expected %h got %h", $time,
                             want_result.signed_value, seen_result.signed_value);
                    error_count++;
                end
                if (seen_result.prefix_error !== want_result.prefix_error)
                begin
                    $display("%0t: prefix_error expected %b got %b", $time,
                             want_result.prefix_error, seen_result.prefix_error);
                    error_count++;
                end
                if (seen_result.last_of_byte !== want_result.last_of_byte)
                begin
                    $display("%0t: last_of_byte expected %b got %b", $time,
                             want_result.last_of_byte, seen_result.last_of_byte);
                    error_count++;
                end
            end
        end
    end

    // short codewords: zero-length prefix eight times in a byte, then short codewords
    // with positive se values
    task automatic test_short_codes();
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h26, 1'b0);
    endtask

    // longest legal prefix with all-ones and all-zeros suffix, then a prefix that
    // overflows in the middle of a byte and codewords right after the error
    task automatic test_prefix_extremes();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hF0, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0F, 1'b0);
    endtask

    // restart drops a partial prefix and a partial suffix; a byte with no result
    task automatic test_restart();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h40, 1'b1);
    endtask

    // well-formed codeword streams packed into bytes, with the odd restart breaking them
    task automatic test_random_streams(input int n_bytes, input int restart_pct);
        int         target;
        int         pick;
        int         zeros;
        logic [7:0] b;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            // prefix length: mostly short, some long, a few overflowing
            pick = $urandom_range(99);
            if (pick < 55)
                zeros = $urandom_range(3);
            else if (pick < 80)
                zeros = $urandom_range(11, 4);
            else if (pick < 95)
                zeros = $urandom_range(31, 12);
            else
                zeros = MAX_PREFIX + 1;
            for (int i = 0; i < zeros; i++)
                stream_bits = {stream_bits, 1'b0};
            if (zeros <= MAX_PREFIX)
            begin
                stream_bits = {stream_bits, 1'b1};
                for (int i = 0; i < zeros; i++)
                    stream_bits = {stream_bits, 1'($urandom_range(1))};
            end
            while (stream_bits.size() >= 8)
            begin
                for (int j = 7; j >= 0; j--)
                    b[j] = stream_bits.pop_front();
                send_byte(b, $urandom_range(99) < restart_pct);
            end
        end
        // pad the tail with ones so no partial codeword is left
        if (stream_bits.size() != 0)
        begin
            while (stream_bits.size() < 8)
                stream_bits = {stream_bits, 1'b1};
            for (int j = 7; j >= 0; j--)
                b[j] = stream_bits.pop_front();
            send_byte(b, 1'b0);
        end
    endtask

    // noise bytes, zero-heavy so long prefixes and errors come up too
    task automatic test_random_noise(input int n_bytes);
        logic [7:0] b;
        for (int i = 0; i < n_bytes; i++)
        begin
            b = ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom_range(255));
            send_byte(b, $urandom_range(99) < 5);
        end
    endtask

    // back-to-back transactions on both sides
    task automatic test_no_idle(input int n_bytes);
        steady_stretch <= 1'b1;
        test_random_streams(n_bytes, 2);
        steady_stretch <= 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_codes();
        test_prefix_extremes();
        test_restart();
        wait_for_results();

        test_random_streams(120, 3);
        // let the output run dry mid-stream, then carry on
        wait_for_results();
        test_random_streams(120, 3);
        test_random_noise(80);
        test_no_idle(60);

        wait_for_results();
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
